/* hw/rtl/lfpd_pkg.sv */
// ----------------------------------------------------------------------------
// lfpd_pkg: shared types and constants of the line follower PID drive
// Register indexes, reset values, datapath widths and the microcode ROM
// that sequences one control update.
// ----------------------------------------------------------------------------
package lfpd_pkg;

  // Field and datapath widths
  localparam int unsigned GainW   = 16;
  localparam int unsigned SpeedW  = 8;
  localparam int unsigned EchoW   = 20;
  localparam int unsigned PosW    = 13;
  localparam int unsigned SumW    = 32;
  localparam int unsigned MulBW   = SumW + 1;
  localparam int unsigned ProdW   = GainW + MulBW;
  localparam int unsigned AccW    = ProdW + 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = EchoW;
  localparam int unsigned DivSteps = SpeedW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_DERIV_GAIN  = 3'd2,
    REG_TOP_SPEED   = 3'd3,
    REG_FLOOR_SPEED = 3'd4,
    REG_ECHO_LIMIT  = 3'd5
  } reg_idx_e;

  // Reset values
  localparam logic [GainW-1:0]  PropGainRst   = 16'd26;
  localparam logic [GainW-1:0]  IntegGainRst  = 16'd0;
  localparam logic [GainW-1:0]  DerivGainRst  = 16'd0;
  localparam logic [SpeedW-1:0] TopSpeedRst   = 8'd220;
  localparam logic [SpeedW-1:0] FloorSpeedRst = 8'd170;
  localparam logic [EchoW-1:0]  EchoLimitRst  = 20'd588;

  // Microcode step addresses
  localparam int unsigned UpcW = 4;
  localparam logic [UpcW-1:0] UPC_IDLE   = 4'd0;
  localparam logic [UpcW-1:0] UPC_ERR    = 4'd1;
  localparam logic [UpcW-1:0] UPC_MUL_P  = 4'd2;
  localparam logic [UpcW-1:0] UPC_MUL_I  = 4'd3;
  localparam logic [UpcW-1:0] UPC_MUL_D  = 4'd4;
  localparam logic [UpcW-1:0] UPC_ADD    = 4'd5;
  localparam logic [UpcW-1:0] UPC_CLAMP  = 4'd6;
  localparam logic [UpcW-1:0] UPC_MUL_L  = 4'd7;
  localparam logic [UpcW-1:0] UPC_MUL_R  = 4'd8;
  localparam logic [UpcW-1:0] UPC_DINIT  = 4'd9;
  localparam logic [UpcW-1:0] UPC_DIV    = 4'd10;
  localparam logic [UpcW-1:0] UPC_OUT    = 4'd11;

  // Multiplier operand select
  typedef enum logic [2:0] {
    MS_NONE = 3'd0,
    MS_P    = 3'd1,
    MS_I    = 3'd2,
    MS_D    = 3'd3,
    MS_L    = 3'd4,
    MS_R    = 3'd5
  } msel_e;

  // Accumulator operation
  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2
  } acc_op_e;

  // Sequencer jump condition
  typedef enum logic [2:0] {
    JC_NEXT     = 3'd0,
    JC_HOLD_IN  = 3'd1,
    JC_HOLD_DIV = 3'd2,
    JC_HOLD_OUT = 3'd3,
    JC_RESTART  = 3'd4
  } jc_e;

  // One control word
  typedef struct packed {
    msel_e   msel;
    logic    mul_en;
    acc_op_e acc_op;
    logic    err_en;
    logic    clamp_en;
    logic    div_init_l;
    logic    div_init_r;
    logic    div_step;
    logic    out_wr;
    jc_e     jc;
  } uword_t;

  // Control of one divider lane
  typedef struct packed {
    logic init;
    logic step;
  } div_ctl_t;

  localparam uword_t UW_NOP = '{msel: MS_NONE, mul_en: 1'b0, acc_op: ACC_HOLD,
                                err_en: 1'b0, clamp_en: 1'b0, div_init_l: 1'b0,
                                div_init_r: 1'b0, div_step: 1'b0, out_wr: 1'b0,
                                jc: JC_NEXT};

  // Microcode ROM
  function automatic uword_t ucode(input logic [UpcW-1:0] upc);
    uword_t w;
    w = UW_NOP;
    case (upc)
      UPC_IDLE:  w.jc = JC_HOLD_IN;
      UPC_ERR:   w.err_en = 1'b1;
      UPC_MUL_P: begin
        w.msel = MS_P;
        w.mul_en = 1'b1;
      end
      UPC_MUL_I: begin
        w.msel = MS_I;
        w.mul_en = 1'b1;
        w.acc_op = ACC_LOAD;
      end
      UPC_MUL_D: begin
        w.msel = MS_D;
        w.mul_en = 1'b1;
        w.acc_op = ACC_ADD;
      end
      UPC_ADD:   w.acc_op = ACC_ADD;
      UPC_CLAMP: w.clamp_en = 1'b1;
      UPC_MUL_L: begin
        w.msel = MS_L;
        w.mul_en = 1'b1;
      end
      UPC_MUL_R: begin
        w.msel = MS_R;
        w.mul_en = 1'b1;
        w.div_init_l = 1'b1;
      end
      UPC_DINIT: w.div_init_r = 1'b1;
      UPC_DIV: begin
        w.div_step = 1'b1;
        w.jc = JC_HOLD_DIV;
      end
      UPC_OUT: begin
        w.out_wr = 1'b1;
        w.jc = JC_HOLD_OUT;
      end
      default:   w.jc = JC_RESTART;
    endcase
    return w;
  endfunction

endpackage

/* hw/rtl/lfpd_div_lane.sv */
// ----------------------------------------------------------------------------
// lfpd_div_lane: one bit per cycle restoring divider lane
// Divides a 16-bit dividend by an 8-bit divisor when the quotient is known
// to fit in 8 bits; the high byte seeds the partial remainder.
// ----------------------------------------------------------------------------
module lfpd_div_lane (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  lfpd_pkg::div_ctl_t                    ctl_i,
  input  logic [2*lfpd_pkg::SpeedW-1:0]         dvd_i,
  input  logic [lfpd_pkg::SpeedW-1:0]           dvs_i,
  output logic [lfpd_pkg::SpeedW-1:0]           quo_o
);

  logic [lfpd_pkg::SpeedW-1:0] rem_q, rem_d;
  logic [lfpd_pkg::SpeedW-1:0] low_q, low_d;
  logic [lfpd_pkg::SpeedW-1:0] quo_q, quo_d;
  logic [lfpd_pkg::SpeedW:0]   trial;
  logic                        fits;

  // Shift in next dividend bit and try the subtraction
  always_comb begin
    trial = {rem_q, low_q[lfpd_pkg::SpeedW-1]};
    fits  = trial >= {1'b0, dvs_i};
    rem_d = rem_q;
    low_d = low_q;
    quo_d = quo_q;
    if (ctl_i.init) begin
      rem_d = dvd_i[2*lfpd_pkg::SpeedW-1:lfpd_pkg::SpeedW];
      low_d = dvd_i[lfpd_pkg::SpeedW-1:0];
      quo_d = '0;
    end else if (ctl_i.step) begin
      rem_d = fits ? lfpd_pkg::SpeedW'(trial - {1'b0, dvs_i})
                   : trial[lfpd_pkg::SpeedW-1:0];
      low_d = {low_q[lfpd_pkg::SpeedW-2:0], 1'b0};
      quo_d = {quo_q[lfpd_pkg::SpeedW-2:0], fits};
    end
  end

  // Remainder and quotient registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
    quo_q <= quo_d;
  end

  assign quo_o = quo_q;

  // Lane is driven by at most one command at a time
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl_i.init && ctl_i.step))
    else $error("divider lane: init and step together");

  // Loading a dividend clears the quotient
  a_init_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.init |=> quo_q == '0)
    else $error("divider lane: quotient not cleared on init");

  // Each step shifts a zero into the low dividend bits
  a_step_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.step && !ctl_i.init) |=> low_q[0] == 1'b0)
    else $error("divider lane: dividend bits not shifted");

endmodule

/* hw/rtl/line_follow_pid_motor_drive_core.sv */
// ----------------------------------------------------------------------------
// line_follow_pid_motor_drive_core: PID line follower with differential drive
// Microcoded sequencer over one shared multiplier, an accumulator and two
// divider lanes; turns a line position and echo time into wheel duties.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one word: line position
//   and ultrasonic echo time. Output channel (out_valid_o / out_stall_i)
//   returns one word per input: left and right duty and the obstacle flag.
//   A word is taken when valid is high and stall is low.
//   The program runs 11 steps, the division step repeating once per
//   quotient bit, one quotient bit of both wheels per cycle; this loop
//   sets the cost. The next word is taken only after the program ends:
//   in_stall_o is low only while the sequencer sits at its idle step.
//   The result sits in an output register, so the next word is accepted
//   while a result waits. If the receiver stalls and the next result is
//   ready, the sequencer holds on its last step until the register frees.
//   Reset clears the integral, the previous error, the output valid and
//   loads the default gains and speeds. Registers may be written through
//   the cfg port whenever the block is idle.
// ----------------------------------------------------------------------------
module line_follow_pid_motor_drive_core #(
  parameter int unsigned SENSORS = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [lfpd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lfpd_pkg::CfgW-1:0]     cfg_wdata_i,
  // input words
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [lfpd_pkg::PosW-1:0]     line_position_i,
  input  logic [lfpd_pkg::EchoW-1:0]    echo_time_us_i,
  // result words
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [lfpd_pkg::SpeedW-1:0]   left_duty_o,
  output logic [lfpd_pkg::SpeedW-1:0]   right_duty_o,
  output logic                          obstacle_stop_o
);

  localparam int unsigned PosMax = (SENSORS - 1) * 1000;
  localparam int unsigned Center = (SENSORS - 1) * 500;
  localparam int unsigned ErrW   = $clog2(Center + 1) + 1;
  localparam int unsigned CmpW   = (ErrW > lfpd_pkg::PosW) ? ErrW : lfpd_pkg::PosW;
  localparam int unsigned GW     = lfpd_pkg::GainW;
  localparam int unsigned SW     = lfpd_pkg::SpeedW;
  localparam int unsigned BW     = lfpd_pkg::MulBW;
  localparam int unsigned PW     = lfpd_pkg::ProdW;
  localparam int unsigned AW     = lfpd_pkg::AccW;
  localparam int unsigned NW     = lfpd_pkg::SumW;

  // Configuration registers
  logic [GW-1:0]                 kp_q, ki_q, kd_q;
  logic [SW-1:0]                 top_q, flo_q;
  logic [lfpd_pkg::EchoW-1:0]    lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q  <= lfpd_pkg::PropGainRst;
      ki_q  <= lfpd_pkg::IntegGainRst;
      kd_q  <= lfpd_pkg::DerivGainRst;
      top_q <= lfpd_pkg::TopSpeedRst;
      flo_q <= lfpd_pkg::FloorSpeedRst;
      lim_q <= lfpd_pkg::EchoLimitRst;
    end else if (cfg_we_i) begin
      case (lfpd_pkg::reg_idx_e'(cfg_idx_i))
        lfpd_pkg::REG_PROP_GAIN:   kp_q  <= cfg_wdata_i[GW-1:0];
        lfpd_pkg::REG_INTEG_GAIN:  ki_q  <= cfg_wdata_i[GW-1:0];
        lfpd_pkg::REG_DERIV_GAIN:  kd_q  <= cfg_wdata_i[GW-1:0];
        lfpd_pkg::REG_TOP_SPEED:   top_q <= cfg_wdata_i[SW-1:0];
        lfpd_pkg::REG_FLOOR_SPEED: flo_q <= cfg_wdata_i[SW-1:0];
        lfpd_pkg::REG_ECHO_LIMIT:  lim_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Sequencer
  logic [lfpd_pkg::UpcW-1:0]    upc_q, upc_d;
  lfpd_pkg::uword_t             uw;
  logic [lfpd_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic                         in_acc, out_acc, out_free;
  logic                         out_valid_q;

  assign uw         = lfpd_pkg::ucode(upc_q);
  assign in_stall_o = (upc_q != lfpd_pkg::UPC_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    case (uw.jc)
      lfpd_pkg::JC_NEXT:     upc_d = upc_q + 1'b1;
      lfpd_pkg::JC_HOLD_IN:  upc_d = in_acc ? upc_q + 1'b1 : upc_q;
      lfpd_pkg::JC_HOLD_DIV: upc_d = (cnt_q != '0) ? upc_q : upc_q + 1'b1;
      lfpd_pkg::JC_HOLD_OUT: upc_d = out_free ? lfpd_pkg::UPC_IDLE : upc_q;
      default:               upc_d = lfpd_pkg::UPC_IDLE;
    endcase
    cnt_d = cnt_q;
    if (uw.div_init_r) begin
      cnt_d = lfpd_pkg::DivCntW'(lfpd_pkg::DivSteps - 1);
    end else if (uw.div_step && cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= lfpd_pkg::UPC_IDLE;
      cnt_q <= '0;
    end else begin
      upc_q <= upc_d;
      cnt_q <= cnt_d;
    end
  end

  // Captured input word
  logic [lfpd_pkg::PosW-1:0]  pos_q;
  logic [lfpd_pkg::EchoW-1:0] echo_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pos_q  <= line_position_i;
      echo_q <= echo_time_us_i;
    end
  end

  // Error, derivative and saturating integral
  logic [CmpW-1:0]          pos_ext;
  logic [ErrW-1:0]          pos_c;
  logic signed [ErrW:0]     err_wide;
  logic signed [ErrW-1:0]   err_q, prev_q;
  logic signed [ErrW:0]     deriv_q;
  logic signed [NW-1:0]     esum_q;
  logic signed [NW:0]       esum_sum;
  logic signed [NW-1:0]     esum_sat;

  always_comb begin
    pos_ext  = CmpW'(pos_q);
    pos_c    = (pos_ext > CmpW'(PosMax)) ? ErrW'(PosMax) : ErrW'(pos_ext);
    err_wide = $signed({1'b0, pos_c}) - $signed((ErrW+1)'(Center));
    esum_sum = {esum_q[NW-1], esum_q}
             + {{(NW+1-ErrW){err_wide[ErrW-1]}}, err_wide[ErrW-1:0]};
    if (esum_sum[NW] != esum_sum[NW-1]) begin
      esum_sat = esum_sum[NW] ? {1'b1, {(NW-1){1'b0}}} : {1'b0, {(NW-1){1'b1}}};
    end else begin
      esum_sat = esum_sum[NW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esum_q <= '0;
      prev_q <= '0;
    end else if (uw.err_en) begin
      esum_q <= esum_sat;
      prev_q <= err_wide[ErrW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (uw.err_en) begin
      err_q   <= err_wide[ErrW-1:0];
      deriv_q <= $signed({err_wide[ErrW-1], err_wide[ErrW-1:0]})
               - $signed({prev_q[ErrW-1], prev_q});
    end
  end

  // Shared multiplier with registered product
  logic signed [GW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] prod_q;
  logic [SW-1:0]        sl_q, sr_q, range_q, flo_eff_q;

  always_comb begin
    case (uw.msel)
      lfpd_pkg::MS_P: begin
        mul_a = kp_q;
        mul_b = {{(BW-ErrW){err_q[ErrW-1]}}, err_q};
      end
      lfpd_pkg::MS_I: begin
        mul_a = ki_q;
        mul_b = {esum_q[NW-1], esum_q};
      end
      lfpd_pkg::MS_D: begin
        mul_a = kd_q;
        mul_b = {{(BW-ErrW-1){deriv_q[ErrW]}}, deriv_q};
      end
      lfpd_pkg::MS_L: begin
        mul_a = $signed({{(GW-SW){1'b0}}, range_q});
        mul_b = $signed({{(BW-SW){1'b0}}, sl_q});
      end
      lfpd_pkg::MS_R: begin
        mul_a = $signed({{(GW-SW){1'b0}}, range_q});
        mul_b = $signed({{(BW-SW){1'b0}}, sr_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (uw.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
  end

  // Accumulator of the PID terms
  logic signed [AW-1:0] acc_q;
  logic signed [AW-1:0] prod_ext;

  assign prod_ext = {{(AW-PW){prod_q[PW-1]}}, prod_q};

  always_ff @(posedge clk_i) begin
    case (uw.acc_op)
      lfpd_pkg::ACC_LOAD: acc_q <= prod_ext;
      lfpd_pkg::ACC_ADD:  acc_q <= acc_q + prod_ext;
      default: ;
    endcase
  end

  // Clamp to +/- top*256 and split into wheel speeds
  logic signed [SW+9:0] bound;
  logic signed [AW-1:0] bound_ext;
  logic signed [SW+9:0] sc;
  logic [SW+9:0]        lsum, rsum;
  logic [SW:0]          lspd, rspd;
  logic [SW-1:0]        flo_eff;

  always_comb begin
    bound     = $signed({2'b00, top_q, 8'h00});
    bound_ext = {{(AW-SW-10){1'b0}}, bound};
    if (acc_q > bound_ext) begin
      sc = bound;
    end else if (acc_q < -bound_ext) begin
      sc = -bound;
    end else begin
      sc = acc_q[SW+9:0];
    end
    lsum    = bound + sc;
    rsum    = bound - sc;
    lspd    = lsum[SW+8:8];
    rspd    = rsum[SW+8:8];
    flo_eff = (flo_q > top_q) ? top_q : flo_q;
  end

  always_ff @(posedge clk_i) begin
    if (uw.clamp_en) begin
      sl_q      <= (lspd > {1'b0, top_q}) ? top_q : lspd[SW-1:0];
      sr_q      <= (rspd > {1'b0, top_q}) ? top_q : rspd[SW-1:0];
      range_q   <= top_q - flo_eff;
      flo_eff_q <= flo_eff;
    end
  end

  // Remap divisions, one lane per wheel
  lfpd_pkg::div_ctl_t ctl_l, ctl_r;
  logic [SW-1:0]      quo_l, quo_r;

  assign ctl_l = '{init: uw.div_init_l, step: uw.div_step};
  assign ctl_r = '{init: uw.div_init_r, step: uw.div_step};

  lfpd_div_lane u_div_l (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl_l),
    .dvd_i  (prod_q[2*SW-1:0]),
    .dvs_i  (top_q),
    .quo_o  (quo_l)
  );

  lfpd_div_lane u_div_r (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl_r),
    .dvd_i  (prod_q[2*SW-1:0]),
    .dvs_i  (top_q),
    .quo_o  (quo_r)
  );

  // Output register
  logic          out_wr;
  logic          stop;
  logic [SW-1:0] left_q, right_q;
  logic          stop_q;

  assign out_wr = uw.out_wr && out_free;
  assign stop   = (echo_q <= lim_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_wr) begin
      out_valid_q <= 1'b1;
    end else if (out_acc) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_wr) begin
      stop_q <= stop;
      if (stop || top_q == '0) begin
        left_q  <= '0;
        right_q <= '0;
      end else begin
        left_q  <= flo_eff_q + quo_l;
        right_q <= flo_eff_q + quo_r;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign left_duty_o     = left_q;
  assign right_duty_o    = right_q;
  assign obstacle_stop_o = stop_q;

  // Checks
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> upc_q == lfpd_pkg::UPC_ERR)
    else $error("sequencer did not start after accepting a word");

  a_div_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == lfpd_pkg::UPC_DIV && cnt_q != '0) |=> upc_q == lfpd_pkg::UPC_DIV)
    else $error("division loop left early");

  a_valid_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(upc_q) == lfpd_pkg::UPC_OUT)
    else $error("result valid raised outside the output step");

  a_stop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && stop_q) |-> (left_q == '0 && right_q == '0))
    else $error("obstacle stop with nonzero duty");

  a_err_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    uw.err_en |-> $past(upc_q) == lfpd_pkg::UPC_IDLE)
    else $error("integral updated without a new word");

endmodule

/* bench/tb_line_follow_pid_motor_drive_core.sv */
// ----------------------------------------------------------------------------
// tb_line_follow_pid_motor_drive_core: self-checking bench of the PID drive
// A queue-fed driver sends line position / echo words while a clocked monitor
// checks every duty word against an in-bench PID and remap predictor. Runs
// directed corner words, then random line walks under many register settings
// with random idle bursts, a long output hold and a final quiet stretch.
// ----------------------------------------------------------------------------
module tb_line_follow_pid_motor_drive_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SENSORS      = 6;
  localparam longint      MaxPos       = (SENSORS - 1) * 1000;
  localparam longint      CenterPos    = (SENSORS - 1) * 500;
  localparam int          DrainCycles  = 32;
  localparam int          HoldAt       = 300;
  localparam int          HoldCycles   = 300;
  localparam int          CycleLimit   = 500000;
  localparam int          RandPhases   = 10;
  localparam int          PhaseWords   = 133;
  localparam int          WordSlots    = 2048;
  // indexes that map to no register
  localparam logic [lfpd_pkg::CfgIdxW-1:0] REG_SPARE_A = 3'd6;
  localparam logic [lfpd_pkg::CfgIdxW-1:0] REG_SPARE_B = 3'd7;

  typedef struct {
    logic [lfpd_pkg::PosW-1:0]  pos;
    logic [lfpd_pkg::EchoW-1:0] echo;
  } word_t;

  typedef struct {
    logic [lfpd_pkg::SpeedW-1:0] left;
    logic [lfpd_pkg::SpeedW-1:0] right;
    logic                        stop;
  } duty_t;

  // DUT signals
  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [lfpd_pkg::CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [lfpd_pkg::CfgW-1:0]     cfg_wdata_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic [lfpd_pkg::PosW-1:0]     line_position_i = '0;
  logic [lfpd_pkg::EchoW-1:0]    echo_time_us_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [lfpd_pkg::SpeedW-1:0]   left_duty_o;
  logic [lfpd_pkg::SpeedW-1:0]   right_duty_o;
  logic                          obstacle_stop_o;

  // Register shadow and controller state of the predictor
  logic signed [lfpd_pkg::GainW-1:0] gain_p = lfpd_pkg::PropGainRst;
  logic signed [lfpd_pkg::GainW-1:0] gain_i = lfpd_pkg::IntegGainRst;
  logic signed [lfpd_pkg::GainW-1:0] gain_d = lfpd_pkg::DerivGainRst;
  logic [lfpd_pkg::SpeedW-1:0]       top_spd = lfpd_pkg::TopSpeedRst;
  logic [lfpd_pkg::SpeedW-1:0]       floor_spd = lfpd_pkg::FloorSpeedRst;
  logic [lfpd_pkg::EchoW-1:0]        echo_lim = lfpd_pkg::EchoLimitRst;
  int                                err_sum = 0;
  int                                prev_err = 0;

  // Bench bookkeeping: pending words and expected duty words, ring buffers
  word_t word_mem [WordSlots];
  duty_t duty_mem [WordSlots];
  int    word_wr = 0;
  int    word_rd = 0;
  int    duty_wr = 0;
  int    duty_rd = 0;
  word_t next_word;
  duty_t got_duty;
  duty_t want_duty;
  int    words_taken = 0;
  int    stops_seen = 0;
  int    err_count = 0;
  int    settings_count = 0;
  int    cycle_count = 0;
  int    src_gap = 0;
  int    sink_gap = 0;
  int    hold_left = 0;
  logic  hold_done = 1'b0;
  logic  quiet = 1'b0;

  line_follow_pid_motor_drive_core #(
    .SENSORS(SENSORS)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .line_position_i(line_position_i),
    .echo_time_us_i (echo_time_us_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .left_duty_o    (left_duty_o),
    .right_duty_o   (right_duty_o),
    .obstacle_stop_o(obstacle_stop_o)
  );

  always #4 clk_i = ~clk_i;

  // Queue one input word for the driver
  function automatic void add_word(input logic [lfpd_pkg::PosW-1:0] p,
                                   input logic [lfpd_pkg::EchoW-1:0] e);
    word_mem[word_wr % WordSlots].pos = p;
    word_mem[word_wr % WordSlots].echo = e;
    word_wr++;
  endfunction

  // Wheel speed into the floor..top duty band
  function automatic logic [lfpd_pkg::SpeedW-1:0] scale_duty(input longint spd,
                                                             input longint tp,
                                                             input longint fl);
    longint s;
    s = spd;
    if (s < 0) s = 0;
    if (s > tp) s = tp;
    if (tp == 0) return '0;
    return lfpd_pkg::SpeedW'(fl + (s * (tp - fl)) / tp);
  endfunction

  // One control update: integral, PID sum in Q8.8, clamp, split, remap
  function automatic duty_t pid_drive_step(input logic [lfpd_pkg::PosW-1:0] pos_in,
                                           input logic [lfpd_pkg::EchoW-1:0] echo_in);
    longint pos, err, acc, dlt, corr, bound, lft, rgt, tp, fl;
    duty_t  res;
    pos = longint'(pos_in);
    if (pos > MaxPos) pos = MaxPos;
    err = pos - CenterPos;
    acc = longint'(err_sum) + err;
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    err_sum = int'(acc);
    dlt = err - longint'(prev_err);
    corr = longint'(gain_p) * err + longint'(gain_i) * longint'(err_sum)
         + longint'(gain_d) * dlt;
    tp = longint'(top_spd);
    fl = longint'(floor_spd);
    bound = tp * 256;
    if (corr > bound) corr = bound;
    if (corr < -bound) corr = -bound;
    lft = (bound + corr) / 256;
    rgt = (bound - corr) / 256;
    if (fl > tp) fl = tp;
    prev_err = int'(err);
    if (echo_in <= echo_lim) begin
      res.left = '0;
      res.right = '0;
      res.stop = 1'b1;
    end else begin
      res.left = scale_duty(lft, tp, fl);
      res.right = scale_duty(rgt, tp, fl);
      res.stop = 1'b0;
    end
    return res;
  endfunction

  task automatic note_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, want %0d (word %0d)", what, got, want, words_taken);
    err_count++;
  endtask

  // Register write at an idle point; the shadow follows
  task automatic cfg_write(input logic [lfpd_pkg::CfgIdxW-1:0] idx,
                           input logic [lfpd_pkg::CfgW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      lfpd_pkg::REG_PROP_GAIN:   gain_p = val[lfpd_pkg::GainW-1:0];
      lfpd_pkg::REG_INTEG_GAIN:  gain_i = val[lfpd_pkg::GainW-1:0];
      lfpd_pkg::REG_DERIV_GAIN:  gain_d = val[lfpd_pkg::GainW-1:0];
      lfpd_pkg::REG_TOP_SPEED:   top_spd = val[lfpd_pkg::SpeedW-1:0];
      lfpd_pkg::REG_FLOOR_SPEED: floor_spd = val[lfpd_pkg::SpeedW-1:0];
      lfpd_pkg::REG_ECHO_LIMIT:  echo_lim = val[lfpd_pkg::EchoW-1:0];
      default: ;
    endcase
  endtask

  // Wait until every queued word went in and every duty word came back
  task automatic wait_idle();
    while (word_wr != word_rd || in_valid_i || duty_wr != duty_rd) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Driver: present words from the queue, random gaps between them
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      src_gap = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        duty_mem[duty_wr % WordSlots] = pid_drive_step(line_position_i, echo_time_us_i);
        duty_wr++;
        words_taken++;
        if (!quiet && $urandom_range(0, 3) == 0) src_gap = $urandom_range(1, 12);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (src_gap > 0) begin
          src_gap--;
          // chain bursts now and then so valid rises late in the program too
          if (src_gap == 0 && !quiet && $urandom_range(0, 2) == 0)
            src_gap = $urandom_range(1, 12);
          in_valid_i <= 1'b0;
        end else if (word_wr != word_rd) begin
          next_word = word_mem[word_rd % WordSlots];
          word_rd++;
          in_valid_i <= 1'b1;
          line_position_i <= next_word.pos;
          echo_time_us_i <= next_word.echo;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long output hold, once, so the block backs up into its input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && words_taken >= HoldAt) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: random stall bursts, check each duty word in order
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      sink_gap = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got_duty.left = left_duty_o;
        got_duty.right = right_duty_o;
        got_duty.stop = obstacle_stop_o;
        if (duty_wr == duty_rd) begin
          note_mismatch("duty word with none pending", int'(got_duty.left), -1);
        end else begin
          want_duty = duty_mem[duty_rd % WordSlots];
          duty_rd++;
          if (got_duty.left !== want_duty.left)
            note_mismatch("left_duty", int'(got_duty.left), int'(want_duty.left));
          if (got_duty.right !== want_duty.right)
            note_mismatch("right_duty", int'(got_duty.right), int'(want_duty.right));
          if (got_duty.stop !== want_duty.stop)
            note_mismatch("obstacle_stop", int'(got_duty.stop), int'(want_duty.stop));
          if (want_duty.stop) stops_seen++;
        end
      end
      if (sink_gap > 0) sink_gap--;
      else if (!quiet && $urandom_range(0, 9) == 0) sink_gap = $urandom_range(1, 12);
      out_stall_i <= (sink_gap > 0) || (hold_left != 0);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d duty words pending", cycle_count,
               duty_wr - duty_rd);
      $display("tb_line_follow_pid_motor_drive_core: done, errors");
      $finish;
    end
  end

  // Stimulus: reset, directed corners, random phases
  initial begin : stim
    int walk_pos;
    int lim;
    int echo_v;
    int pick;
    int tp;
    int fl;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: center, range ends, beyond range, limit edges
    settings_count++;
    @(negedge clk_i);
    add_word(13'd2500, 20'd1000);
    add_word(13'd0, 20'hFFFFF);
    add_word(13'd5000, 20'd589);
    add_word(13'h1FFF, 20'd2000);
    add_word(13'd5001, 20'd700);
    add_word(13'd2500, 20'd588);
    add_word(13'd3000, 20'd0);
    add_word(13'd1234, 20'd100000);
    wait_idle();

    // extreme gains, full band, zero echo limit
    cfg_write(lfpd_pkg::REG_PROP_GAIN, 20'hF7FFF);
    cfg_write(lfpd_pkg::REG_INTEG_GAIN, 20'h08000);
    cfg_write(lfpd_pkg::REG_DERIV_GAIN, 20'h00100);
    cfg_write(lfpd_pkg::REG_TOP_SPEED, 20'h000FF);
    cfg_write(lfpd_pkg::REG_FLOOR_SPEED, 20'hFFF00);
    cfg_write(lfpd_pkg::REG_ECHO_LIMIT, 20'h00000);
    settings_count++;
    @(negedge clk_i);
    add_word(13'd0, 20'd1);
    add_word(13'd5000, 20'd0);
    add_word(13'd2500, 20'd1);
    add_word(13'd4999, 20'h7FFFF);
    add_word(13'd0, 20'hFFFFF);
    wait_idle();

    // floor above top, negative P and D gains
    cfg_write(lfpd_pkg::REG_PROP_GAIN, 20'h0FF00);
    cfg_write(lfpd_pkg::REG_INTEG_GAIN, 20'h00001);
    cfg_write(lfpd_pkg::REG_DERIV_GAIN, 20'h0FFFF);
    cfg_write(lfpd_pkg::REG_TOP_SPEED, 20'd100);
    cfg_write(lfpd_pkg::REG_FLOOR_SPEED, 20'd200);
    cfg_write(lfpd_pkg::REG_ECHO_LIMIT, 20'd10);
    settings_count++;
    @(negedge clk_i);
    add_word(13'd1000, 20'd11);
    add_word(13'd4000, 20'd11);
    add_word(13'd2500, 20'd10);
    wait_idle();

    // top speed zero
    cfg_write(lfpd_pkg::REG_TOP_SPEED, 20'd0);
    cfg_write(lfpd_pkg::REG_FLOOR_SPEED, 20'd0);
    settings_count++;
    @(negedge clk_i);
    add_word(13'd0, 20'd50);
    add_word(13'd5000, 20'd50);
    wait_idle();

    // most negative P and D, largest I, defaults for the rest
    cfg_write(lfpd_pkg::REG_PROP_GAIN, 20'h08000);
    cfg_write(lfpd_pkg::REG_INTEG_GAIN, 20'h07FFF);
    cfg_write(lfpd_pkg::REG_DERIV_GAIN, 20'h08000);
    cfg_write(lfpd_pkg::REG_TOP_SPEED, 20'd220);
    cfg_write(lfpd_pkg::REG_FLOOR_SPEED, 20'd170);
    cfg_write(lfpd_pkg::REG_ECHO_LIMIT, 20'd588);
    cfg_write(REG_SPARE_A, 20'hFFFFF);
    cfg_write(REG_SPARE_B, 20'h5A5A5);
    settings_count++;
    @(negedge clk_i);
    add_word(13'd4095, 20'd4096);
    add_word(13'd2048, 20'd589);
    add_word(13'd6000, 20'd1000);
    add_word(13'd100, 20'd1023);
    wait_idle();

    // random phases: line walks with occasional jumps, noise and obstacles
    walk_pos = 2500;
    for (int k = 0; k < RandPhases; k++) begin
      pick = $urandom_range(0, 3);
      cfg_write(lfpd_pkg::REG_PROP_GAIN, (pick == 0) ? 20'($urandom)
                                         : 20'($urandom_range(0, 1024) - 512));
      pick = $urandom_range(0, 3);
      cfg_write(lfpd_pkg::REG_INTEG_GAIN, (pick == 0) ? 20'($urandom)
                                          : 20'($urandom_range(0, 16) - 8));
      pick = $urandom_range(0, 3);
      cfg_write(lfpd_pkg::REG_DERIV_GAIN, (pick == 0) ? 20'($urandom)
                                          : 20'($urandom_range(0, 2048) - 1024));
      if (k == 2) tp = 255;
      else if (k == 6) tp = 1;
      else tp = $urandom_range(1, 255);
      cfg_write(lfpd_pkg::REG_TOP_SPEED, 20'(tp) | (20'($urandom) & 20'hFFF00));
      if (k == 5) fl = 255;
      else if ($urandom_range(0, 4) == 0) fl = $urandom_range(0, 255);
      else fl = $urandom_range(0, tp);
      cfg_write(lfpd_pkg::REG_FLOOR_SPEED, 20'(fl));
      if (k == 7) lim = 20'hFFFFF;
      else if (k == 8) lim = 0;
      else lim = $urandom_range(0, 3000);
      cfg_write(lfpd_pkg::REG_ECHO_LIMIT, 20'(lim));
      settings_count++;
      @(negedge clk_i);
      quiet = (k == 4) || (k == RandPhases - 1);
      for (int n = 0; n < PhaseWords; n++) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          walk_pos = $urandom_range(0, 8191);
        end else begin
          if (pick == 1) walk_pos = $urandom_range(0, 5000);
          else walk_pos = walk_pos + $urandom_range(0, 600) - 300;
          if (walk_pos < 0) walk_pos = 0;
          if (walk_pos > 5000) walk_pos = 5000;
        end
        pick = $urandom_range(0, 9);
        if (pick < 2) echo_v = $urandom_range(0, lim);
        else if (pick == 2) echo_v = int'(20'($urandom));
        else begin
          echo_v = lim + 1 + $urandom_range(0, 60000);
          if (echo_v > 20'hFFFFF) echo_v = 20'hFFFFF;
        end
        add_word(13'(walk_pos), 20'(echo_v));
        // pull back toward the center after a noise word
        if (walk_pos > 5000) walk_pos = 2500;
      end
      wait_idle();
    end

    if (duty_wr != duty_rd) note_mismatch("duty words never delivered", 0, duty_wr - duty_rd);
    $display("covered %0d words under %0d register settings, %0d obstacle stops",
             words_taken, settings_count, stops_seen);
    $display("including range ends, floor above top, zero top speed and a long output hold");
    if (err_count == 0) begin
      $display("tb_line_follow_pid_motor_drive_core: done, clean");
    end else begin
      $display("tb_line_follow_pid_motor_drive_core: done, errors");
    end
    $finish;
  end

endmodule
